// ===== rtl/wavp_pkg.sv =====
package wavp_pkg;

  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [31:0] TAG_SMPL = 32'h736D706C;
  localparam logic [15:0] FMT_PCM   = 16'h0001;
  localparam logic [15:0] FMT_ADPCM = 16'h0011;
  localparam logic [15:0] FMT_MP3   = 16'h0055;
  localparam logic [31:0] RATE_DEFAULT = 32'd22050;

  localparam logic [2:0] KIND_SAMPLE = 3'd0;
  localparam logic [2:0] KIND_FORMAT = 3'd1;
  localparam logic [2:0] KIND_LOOP   = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  localparam logic [1:0] ERR_ADPCM   = 2'd0;
  localparam logic [1:0] ERR_MP3     = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd2;
  localparam logic [1:0] ERR_NO_FMT  = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  sample_byte;
    logic [1:0]  sample_format;
    logic [31:0] sample_rate;
    logic        loop_flag;
    logic [1:0]  error_code;
    logic        done_res;
  } result_t;

endpackage

// ===== rtl/wavp_parse.sv =====
// Front: per-byte parse of the RIFF stream; at most one result per byte.
module wavp_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  input  logic                 last_byte,
  output logic                 res_valid,
  output wavp_pkg::result_t    res
);

  typedef enum logic [2:0] {
    PH_FILE, PH_CHDR, PH_BODY, PH_PAD, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] field_count, field_count_next;
  logic [31:0] riff_remaining, riff_remaining_next;
  logic [31:0] chunk_size, chunk_size_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] assembly_word, assembly_word_next;
  logic [15:0] format_tag, format_tag_next;
  logic [15:0] channel_count, channel_count_next;
  logic [15:0] bits_per_sample, bits_per_sample_next;
  logic [31:0] rate_reg, rate_reg_next;
  logic [15:0] block_bytes, block_bytes_next;
  logic [15:0] block_offset, block_offset_next;
  logic        fmt_seen, fmt_seen_next;

  logic        r_has, r_end, do_reset;
  wavp_pkg::result_t r;

  always_comb begin
    logic [31:0] fc1, csz, aw, cs1, bo1;
    logic        body_fin, hdr_fin;
    logic [1:0]  bsel;
    phase_next = phase;
    field_count_next = field_count;
    riff_remaining_next = riff_remaining;
    chunk_size_next = chunk_size;
    chunk_tag_next = chunk_tag;
    assembly_word_next = assembly_word;
    format_tag_next = format_tag;
    channel_count_next = channel_count;
    bits_per_sample_next = bits_per_sample;
    rate_reg_next = rate_reg;
    block_bytes_next = block_bytes;
    block_offset_next = block_offset;
    fmt_seen_next = fmt_seen;
    r = '0;
    r_has = 1'b0;
    r_end = 1'b0;
    do_reset = 1'b0;
    body_fin = 1'b0;
    hdr_fin = 1'b0;
    fc1 = field_count + 32'd1;
    bsel = field_count[1:0];
    aw = assembly_word;
    csz = 32'd0;
    cs1 = chunk_size - 32'd1;
    bo1 = {16'd0, block_offset} + 32'd1;

    case (phase)
      PH_DONE: begin
        if (last_byte) do_reset = 1'b1;
      end
      PH_FILE: begin
        if (field_count >= 32'd4 && field_count < 32'd8) begin
          if (field_count == 32'd4) aw = '0;
          aw = aw | ({24'd0, byte_in} << (8 * bsel));
          assembly_word_next = aw;
        end
        field_count_next = fc1;
        if (fc1 == 32'd12) begin
          riff_remaining_next = ((aw + 32'd1) & ~32'd1) - 32'd4;
          field_count_next = '0;
          phase_next = PH_CHDR;
          if (riff_remaining_next == '0) r_end = 1'b1;
        end
      end
      PH_CHDR: begin
        if (field_count < 32'd4) begin
          chunk_tag_next = {chunk_tag[23:0], byte_in};
        end else begin
          if (field_count == 32'd4) aw = '0;
          aw = aw | ({24'd0, byte_in} << (8 * bsel));
          assembly_word_next = aw;
        end
        field_count_next = fc1;
        if (fc1 == 32'd8) begin
          csz = aw;
          chunk_size_next = csz;
          riff_remaining_next = riff_remaining - (((csz + 32'd1) & ~32'd1) + 32'd8);
          field_count_next = '0;
          assembly_word_next = '0;
          hdr_fin = 1'b1;
          if (chunk_tag == wavp_pkg::TAG_DATA) begin
            if (!fmt_seen || format_tag != wavp_pkg::FMT_PCM) begin
              r_has = 1'b1;
              r.kind = wavp_pkg::KIND_ERROR;
              r.error_code = !fmt_seen ? wavp_pkg::ERR_NO_FMT :
                             format_tag == wavp_pkg::FMT_ADPCM ? wavp_pkg::ERR_ADPCM :
                             format_tag == wavp_pkg::FMT_MP3 ? wavp_pkg::ERR_MP3 :
                             wavp_pkg::ERR_UNKNOWN;
              r_end = 1'b1;
              hdr_fin = 1'b0;
            end else begin
              block_offset_next = '0;
            end
          end else if (chunk_tag == wavp_pkg::TAG_FMT) begin
            format_tag_next = '0;
            channel_count_next = '0;
            bits_per_sample_next = '0;
            block_bytes_next = '0;
          end
          if (hdr_fin) begin
            if (csz == '0) body_fin = 1'b1;
            else phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (chunk_tag == wavp_pkg::TAG_FMT) begin
          if (field_count < 32'd2)
            format_tag_next = format_tag | ({8'd0, byte_in} << (8 * field_count[0]));
          else if (field_count < 32'd4)
            channel_count_next = channel_count | ({8'd0, byte_in} << (8 * field_count[0]));
          else if (field_count < 32'd8)
            assembly_word_next = assembly_word | ({24'd0, byte_in} << (8 * bsel));
          else if (field_count >= 32'd12 && field_count < 32'd14)
            block_bytes_next = block_bytes | ({8'd0, byte_in} << (8 * field_count[0]));
          else if (field_count >= 32'd14 && field_count < 32'd16)
            bits_per_sample_next = bits_per_sample
                                   | ({8'd0, byte_in} << (8 * field_count[0]));
        end else if (chunk_tag == wavp_pkg::TAG_SMPL) begin
          if (field_count >= 32'd28 && field_count < 32'd32)
            assembly_word_next = assembly_word | ({24'd0, byte_in} << (8 * bsel));
        end else if (chunk_tag == wavp_pkg::TAG_DATA) begin
          if (block_bytes != '0 &&
              (block_offset != '0 || chunk_size >= {16'd0, block_bytes})) begin
            r_has = 1'b1;
            r.kind = wavp_pkg::KIND_SAMPLE;
            r.sample_byte = byte_in;
            block_offset_next = (bo1[15:0] == block_bytes) ? 16'd0 : bo1[15:0];
          end
        end
        aw = assembly_word_next;
        field_count_next = fc1;
        chunk_size_next = cs1;
        if (cs1 == '0) body_fin = 1'b1;
      end
      default: begin  // PH_PAD
        if (riff_remaining == '0) r_end = 1'b1;
        else begin
          phase_next = PH_CHDR;
          field_count_next = '0;
        end
      end
    endcase

    if (body_fin) begin
      if (chunk_tag == wavp_pkg::TAG_FMT) begin
        fmt_seen_next = 1'b1;
        if (format_tag_next == wavp_pkg::FMT_PCM) begin
          rate_reg_next = aw;
          r_has = 1'b1;
          r.kind = wavp_pkg::KIND_FORMAT;
          r.sample_rate = aw;
          r.sample_format = (channel_count_next == 16'd1) ?
                            ((bits_per_sample_next == 16'd8) ? 2'd0 : 2'd1) :
                            ((bits_per_sample_next == 16'd8) ? 2'd2 : 2'd3);
        end
      end else if (chunk_tag == wavp_pkg::TAG_SMPL) begin
        r_has = 1'b1;
        r.kind = wavp_pkg::KIND_LOOP;
        r.loop_flag = (aw != '0);
      end
      if (field_count_next[0]) phase_next = PH_PAD;
      else if (riff_remaining_next == '0) r_end = 1'b1;
      else begin
        phase_next = PH_CHDR;
        field_count_next = '0;
      end
    end

    if (phase != PH_DONE) begin
      if (last_byte) r_end = 1'b1;
      if (r_end) begin
        if (!r_has) begin
          r_has = 1'b1;
          r.kind = wavp_pkg::KIND_END;
        end
        r.done_res = 1'b1;
        if (last_byte) do_reset = 1'b1;
        else phase_next = PH_DONE;
      end
    end
  end

  assign res_valid = step && r_has;
  assign res = r;

  always_ff @(posedge clk) begin
    if (rst || (step && do_reset)) begin
      phase <= PH_FILE;
      field_count <= '0;
      riff_remaining <= '0;
      chunk_size <= '0;
      chunk_tag <= '0;
      assembly_word <= '0;
      format_tag <= '0;
      channel_count <= '0;
      bits_per_sample <= '0;
      rate_reg <= wavp_pkg::RATE_DEFAULT;
      block_bytes <= '0;
      block_offset <= '0;
      fmt_seen <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      field_count <= field_count_next;
      riff_remaining <= riff_remaining_next;
      chunk_size <= chunk_size_next;
      chunk_tag <= chunk_tag_next;
      assembly_word <= assembly_word_next;
      format_tag <= format_tag_next;
      channel_count <= channel_count_next;
      bits_per_sample <= bits_per_sample_next;
      rate_reg <= rate_reg_next;
      block_bytes <= block_bytes_next;
      block_offset <= block_offset_next;
      fmt_seen <= fmt_seen_next;
    end
  end

endmodule

// ===== rtl/wavp_queue.sv =====
// Back: small result FIFO feeding the output port.
module wavp_queue #(
  parameter int DEPTH = wavp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wavp_pkg::result_t din,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output wavp_pkg::result_t dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  wavp_pkg::result_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          pop;

  assign pop = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign full = (count == (AW+1)'(DEPTH));
  assign dout = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== rtl/wav_riff_chunk_parser_core.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         in_valid / in_ready        byte_in, last_byte
// result    out        out_valid / out_ready      kind, sample_byte, sample_format,
//                                                 sample_rate, loop_flag, error_code,
//                                                 done_res
//
// One byte per cycle while in_ready is high: the parser updates all state from each byte.
// A result request is registered in a QUEUE_DEPTH-entry queue before it shows up at
// the output. Input stalls only when the queue cannot take another result.
// Reset (rst, sync) returns to the file header phase with rate 22050.
module wav_riff_chunk_parser_core #(
  parameter int QUEUE_DEPTH = wavp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  sample_byte,
  output logic [1:0]  sample_format,
  output logic [31:0] sample_rate,
  output logic        loop_flag,
  output logic [1:0]  error_code,
  output logic        done_res
);

  logic              step, res_valid, q_full, q_out_valid;
  wavp_pkg::result_t res, q_dout;

  // Accept a byte whenever the queue has a free slot for its possible result.
  assign in_ready = !q_full;
  assign step = in_valid && in_ready;

  wavp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (byte_in),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wavp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (res_valid),
    .din         (res),
    .full        (q_full),
    .out_valid   (q_out_valid),
    .out_ready   (out_ready),
    .dout        (q_dout)
  );

  assign out_valid     = q_out_valid;
  assign kind          = q_dout.kind;
  assign sample_byte   = q_dout.sample_byte;
  assign sample_format = q_dout.sample_format;
  assign sample_rate   = q_dout.sample_rate;
  assign loop_flag     = q_dout.loop_flag;
  assign error_code    = q_dout.error_code;
  assign done_res      = q_dout.done_res;

endmodule
